[hdl/wsd_pkg.sv]
package wsd_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned OPC_W   = 4;
    localparam int unsigned LEN_W   = 63;
    localparam int unsigned KEY_W   = 32;
    localparam int unsigned HCNT_W  = 4;

    // 7-bit length codes
    localparam logic [6:0] LEN7_SHORT_MAX = 7'd125;
    localparam logic [6:0] LEN7_EXT64     = 7'd127;

    // extended length and key byte counts
    localparam logic [HCNT_W-1:0] EXT16_BYTES = 4'd2;
    localparam logic [HCNT_W-1:0] EXT64_BYTES = 4'd8;
    localparam logic [HCNT_W-1:0] KEY_BYTES   = 4'd4;

    typedef enum logic [2:0] {
        PH_HDR0    = 3'd0,
        PH_HDR1    = 3'd1,
        PH_EXTLEN  = 3'd2,
        PH_KEY     = 3'd3,
        PH_PAYLOAD = 3'd4
    } t_phase;

    typedef struct packed {
        logic [BYTE_W-1:0] payload_byte;
        logic              has_payload;
        logic [OPC_W-1:0]  frame_opcode;
        logic              final_fragment;
        logic [LEN_W-1:0]  frame_length;
        logic              last_of_frame;
    } t_result;

endpackage

[hdl/wsd_in_reg.sv]
module wsd_in_reg
    import wsd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [BYTE_W-1:0] i_rx_byte,
    output logic              o_stall,
    input  logic              i_advance,
    output logic              o_valid,
    output logic [BYTE_W-1:0] o_byte
);

    logic              r_valid;
    logic [BYTE_W-1:0] r_byte;
    logic              w_load;

    // hold the byte until the parser consumes it
    assign o_stall = r_valid & ~i_advance;
    assign w_load  = i_valid & ~o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= 1'b1;
        end else if (i_advance) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_byte <= i_rx_byte;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;

endmodule

[hdl/wsd_parser.sv]
module wsd_parser
    import wsd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [BYTE_W-1:0] i_byte,
    input  logic              i_out_room,
    output logic              o_advance,
    output logic              o_res_valid,
    output t_result           o_result
);

    t_phase            r_phase, n_phase;
    logic              r_fin, n_fin;
    logic [OPC_W-1:0]  r_opcode, n_opcode;
    logic              r_masked, n_masked;
    logic [HCNT_W-1:0] r_hdr_left, n_hdr_left;
    logic [LEN_W-1:0]  r_decl_len, n_decl_len;
    logic [KEY_W-1:0]  r_key, n_key;
    logic [1:0]        r_key_idx, n_key_idx;
    logic [LEN_W-1:0]  r_remaining, n_remaining;

    logic              w_res_valid;
    logic [BYTE_W-1:0] w_res_byte;
    logic              w_res_has;
    logic              w_res_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HDR0;
            r_fin       <= 1'b0;
            r_opcode    <= '0;
            r_masked    <= 1'b0;
            r_hdr_left  <= '0;
            r_decl_len  <= '0;
            r_key       <= '0;
            r_key_idx   <= '0;
            r_remaining <= '0;
        end else if (o_advance) begin
            r_phase     <= n_phase;
            r_fin       <= n_fin;
            r_opcode    <= n_opcode;
            r_masked    <= n_masked;
            r_hdr_left  <= n_hdr_left;
            r_decl_len  <= n_decl_len;
            r_key       <= n_key;
            r_key_idx   <= n_key_idx;
            r_remaining <= n_remaining;
        end
    end

    always_comb begin
        logic [6:0]        len7;
        logic [HCNT_W-1:0] hdr_dec;
        logic [LEN_W-1:0]  rem_dec;
        logic [BYTE_W-1:0] key_byte;
        logic              len_done;
        logic              key_done;

        len7     = i_byte[6:0];
        hdr_dec  = r_hdr_left - 1'b1;
        rem_dec  = r_remaining - 1'b1;
        key_byte = '0;
        len_done = 1'b0;
        key_done = 1'b0;

        n_phase     = r_phase;
        n_fin       = r_fin;
        n_opcode    = r_opcode;
        n_masked    = r_masked;
        n_hdr_left  = r_hdr_left;
        n_decl_len  = r_decl_len;
        n_key       = r_key;
        n_key_idx   = r_key_idx;
        n_remaining = r_remaining;
        w_res_valid = 1'b0;
        w_res_byte  = '0;
        w_res_has   = 1'b0;
        w_res_last  = 1'b0;

        case (r_phase)
            PH_HDR1: begin
                n_masked = i_byte[7];
                if (len7 <= LEN7_SHORT_MAX) begin
                    n_decl_len = {{(LEN_W-7){1'b0}}, len7};
                    len_done   = 1'b1;
                end else begin
                    n_decl_len = '0;
                    n_hdr_left = (len7 == LEN7_EXT64) ? EXT64_BYTES : EXT16_BYTES;
                    n_phase    = PH_EXTLEN;
                end
            end
            PH_EXTLEN: begin
                // shift in big-endian, top bit of a 64-bit length falls off
                n_decl_len = {r_decl_len[LEN_W-9:0], i_byte};
                n_hdr_left = hdr_dec;
                len_done   = (hdr_dec == '0);
            end
            PH_KEY: begin
                n_key      = {r_key[KEY_W-9:0], i_byte};
                n_hdr_left = hdr_dec;
                key_done   = (hdr_dec == '0);
            end
            PH_PAYLOAD: begin
                if (r_masked) begin
                    case (r_key_idx)
                        2'd0:    key_byte = r_key[31:24];
                        2'd1:    key_byte = r_key[23:16];
                        2'd2:    key_byte = r_key[15:8];
                        default: key_byte = r_key[7:0];
                    endcase
                end
                n_key_idx   = r_key_idx + 1'b1;
                n_remaining = rem_dec;
                w_res_valid = 1'b1;
                w_res_byte  = i_byte ^ key_byte;
                w_res_has   = 1'b1;
                w_res_last  = (rem_dec == '0);
                if (rem_dec == '0) begin
                    n_phase = PH_HDR0;
                end
            end
            default: begin
                n_fin    = i_byte[7];
                n_opcode = i_byte[OPC_W-1:0];
                n_phase  = PH_HDR1;
            end
        endcase

        // length known: fetch key if masked, else payload or empty-frame end
        if (len_done) begin
            if (n_masked) begin
                n_key      = '0;
                n_key_idx  = '0;
                n_hdr_left = KEY_BYTES;
                n_phase    = PH_KEY;
            end else begin
                key_done = 1'b1;
            end
        end

        if (key_done) begin
            if (n_decl_len == '0) begin
                w_res_valid = 1'b1;
                w_res_last  = 1'b1;
                n_phase     = PH_HDR0;
            end else begin
                n_remaining = n_decl_len;
                n_key_idx   = '0;
                n_phase     = PH_PAYLOAD;
            end
        end
    end

    assign o_advance   = i_valid & (~w_res_valid | i_out_room);
    assign o_res_valid = i_valid & w_res_valid;

    assign o_result.payload_byte   = w_res_byte;
    assign o_result.has_payload    = w_res_has;
    assign o_result.frame_opcode   = r_opcode;
    assign o_result.final_fragment = r_fin;
    assign o_result.frame_length   = n_decl_len;
    assign o_result.last_of_frame  = w_res_last;

`ifndef NO_ASSERTIONS
    a_payload_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PAYLOAD) |-> (r_remaining != '0))
        else $error("payload phase with nothing remaining");

    a_hdr_count_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_EXTLEN || r_phase == PH_KEY) |-> (r_hdr_left != '0))
        else $error("header phase with zero bytes left");

    a_last_matches_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_result.has_payload && o_result.last_of_frame)
            |-> (r_remaining == {{(LEN_W-1){1'b0}}, 1'b1}))
        else $error("last payload byte flagged early");

    a_advance_leaves_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_advance && r_phase == PH_KEY && r_hdr_left == {{(HCNT_W-1){1'b0}}, 1'b1})
            |=> (r_phase != PH_KEY))
        else $error("key phase overran four bytes");
`endif

endmodule

[hdl/wsd_out_reg.sv]
module wsd_out_reg
    import wsd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  t_result           i_result,
    output logic              o_room,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [BYTE_W-1:0] o_payload_byte,
    output logic              o_has_payload,
    output logic [OPC_W-1:0]  o_frame_opcode,
    output logic              o_final_fragment,
    output logic [LEN_W-1:0]  o_frame_length,
    output logic              o_last_of_frame
);

    logic    r_valid;
    t_result r_result;

    // free when empty or when the held result leaves this edge
    assign o_room = ~r_valid | ~i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (~i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid          = r_valid;
    assign o_payload_byte   = r_result.payload_byte;
    assign o_has_payload    = r_result.has_payload;
    assign o_frame_opcode   = r_result.frame_opcode;
    assign o_final_fragment = r_result.final_fragment;
    assign o_frame_length   = r_result.frame_length;
    assign o_last_of_frame  = r_result.last_of_frame;

`ifndef NO_ASSERTIONS
    a_empty_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !r_result.has_payload)
            |-> (r_result.payload_byte == '0 && r_result.last_of_frame
                 && r_result.frame_length == '0))
        else $error("malformed empty-frame marker");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_load) |-> (!r_valid || !i_stall))
        else $error("result register overwritten while stalled");

    a_empty_is_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_load && !i_stall) |=> !r_valid)
        else $error("result register kept a delivered transaction");
`endif

endmodule

[hdl/websocket_frame_deframer.sv]
// Path: an accepted byte waits in the input register, is parsed as its result loads
//   into the result register, and the result is offered from there.
// Throughput: one byte per cycle unless a result stalls; header bytes yield none,
//   each payload byte one, an empty frame one marker on its last header byte.
// Reset: synchronous, active low; clears both stage valids and the parse state.
module websocket_frame_deframer
    import wsd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // byte stream in
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [BYTE_W-1:0] i_rx_byte,
    // results out
    output logic              o_valid,
    input  logic              i_stall,
    output logic [BYTE_W-1:0] o_payload_byte,
    output logic              o_has_payload,
    output logic [OPC_W-1:0]  o_frame_opcode,
    output logic              o_final_fragment,
    output logic [LEN_W-1:0]  o_frame_length,
    output logic              o_last_of_frame
);

    // Stage 1: input register holds the accepted byte.
    // Stage 2: parser state advances and the result register loads in the same edge.
    // A byte that produces no result (header bytes) never waits for the output side,
    // so headers keep flowing even while a payload result is stalled downstream.

    logic              w_in_valid;
    logic [BYTE_W-1:0] w_in_byte;
    logic              w_advance;
    logic              w_out_room;
    logic              w_res_valid;
    t_result           w_result;

    wsd_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_rx_byte (i_rx_byte),
        .o_stall   (o_stall),
        .i_advance (w_advance),
        .o_valid   (w_in_valid),
        .o_byte    (w_in_byte)
    );

    // Decode header fields, count extended length and key bytes, unmask payload.
    wsd_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_in_valid),
        .i_byte      (w_in_byte),
        .i_out_room  (w_out_room),
        .o_advance   (w_advance),
        .o_res_valid (w_res_valid),
        .o_result    (w_result)
    );

    // Hold each result until the downstream side takes the transaction.
    wsd_out_reg u_out_reg (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_load           (w_res_valid & w_advance),
        .i_result         (w_result),
        .o_room           (w_out_room),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_payload_byte   (o_payload_byte),
        .o_has_payload    (o_has_payload),
        .o_frame_opcode   (o_frame_opcode),
        .o_final_fragment (o_final_fragment),
        .o_frame_length   (o_frame_length),
        .o_last_of_frame  (o_last_of_frame)
    );

`ifndef NO_ASSERTIONS
    a_header_never_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_valid && !w_res_valid) |-> w_advance)
        else $error("header byte held back by output side");

    a_result_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_res_valid && w_advance) |=> o_valid)
        else $error("parsed result not presented");

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (w_in_valid && w_res_valid && o_valid && i_stall))
        else $error("input stalled without a blocked result");
`endif

endmodule
